// ----- design/stalm_pkg.sv -----
// Shared types, widths and codes for the slot table allocator.
// No dependencies; stalm_ctrl, stalm_dp and the top level import this package.
package stalm_pkg;

  localparam int SLOTS_PER_PAGE_DEF = 256;
  localparam int MAX_PAGES_DEF      = 4;

  localparam int ADDR_W   = 52;
  localparam int PI_W     = 16;
  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  localparam logic FUNC_REG   = 1'b0;
  localparam logic FUNC_UNREG = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] page_addr;
    logic [PI_W-1:0]   producer_index;
    logic [SLOT_W-1:0] target_slot;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   assigned_slot;
    logic                has_last;
    logic [SLOT_W-1:0]   last_slot;
    logic [COUNT_W-1:0]  free_slots;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;        // clearing pass, one slot
    logic load;       // capture the input transaction
    logic alloc;      // register: pick slot, update counters
    logic unreg_rd;   // unregister: read valid bit of target
    logic unreg_chk;  // unregister: judge the valid bit
    logic up_step;    // upward free-slot scan, one step
    logic dn_step;    // downward last-entry scan, one step
    logic rel;        // unregister: clear the slot
    logic finish;     // load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic t_oob;
    logic t_empty;
    logic t_last;
    logic alloc_scan;
    logic up_done;
    logic dn_done;
    logic out_busy;
  } sts_t;

endpackage

// ----- design/stalm_stream_if.sv -----
// Valid/ready channel carrying one payload struct per transaction.
// Payload type is set at instantiation (see stalm_pkg).
interface stalm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/stalm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stalm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ----- design/stalm_ctrl.sv -----
// Sequencing state machine of the slot table allocator.
// Depends on stalm_pkg (cmd_t, sts_t, function codes).
module stalm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_func,
  output logic            req_ready,
  output stalm_pkg::cmd_t cmd,
  input  stalm_pkg::sts_t sts
);
  import stalm_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ALLOC = 4'd2;
  localparam logic [3:0] S_URD   = 4'd3;
  localparam logic [3:0] S_UCHK  = 4'd4;
  localparam logic [3:0] S_UP    = 4'd5;
  localparam logic [3:0] S_DN    = 4'd6;
  localparam logic [3:0] S_REL   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = (req_func == FUNC_UNREG) ? S_URD : S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.alloc  = 1'b1;
        state_next = sts.alloc_scan ? S_UP : S_FIN;
      end
      S_URD: begin
        cmd.unreg_rd = 1'b1;
        state_next   = sts.t_oob ? S_FIN : S_UCHK;
      end
      S_UCHK: begin
        cmd.unreg_chk = 1'b1;
        if (sts.t_empty)     state_next = S_FIN;
        else if (sts.t_last) state_next = S_DN;
        else                 state_next = S_REL;
      end
      S_UP: begin
        cmd.up_step = 1'b1;
        if (sts.up_done) state_next = S_FIN;
      end
      S_DN: begin
        cmd.dn_step = 1'b1;
        if (sts.dn_done) state_next = S_REL;
      end
      S_REL: begin
        cmd.rel    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end
endmodule

// ----- design/stalm_dp.sv -----
// Datapath: slot counters, valid-bit and entry RAMs, scan pointer, result register.
// Depends on stalm_pkg and stalm_ram.
module stalm_dp #(
  parameter int SLOTS_PER_PAGE = stalm_pkg::SLOTS_PER_PAGE_DEF,
  parameter int MAX_PAGES      = stalm_pkg::MAX_PAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  stalm_pkg::cmd_t      cmd,
  output stalm_pkg::sts_t      sts,
  input  stalm_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stalm_pkg::out_item_t out_item
);
  import stalm_pkg::*;

  localparam int CAP     = SLOTS_PER_PAGE * MAX_PAGES;
  localparam int IW      = $clog2(CAP);
  localparam int CW      = $clog2(CAP + 1);
  localparam int PW      = $clog2(MAX_PAGES + 1);
  localparam int ENTRY_W = ADDR_W + PI_W;

  // control state
  logic [CW-1:0] nf;         // lowest free slot, or high water
  logic [CW-1:0] hw;
  logic [IW-1:0] last_idx;
  logic          last_pres;
  logic [CW-1:0] fc;
  logic [PW-1:0] pages;
  logic [IW-1:0] clr_ptr;
  logic          chk_v;

  // working registers
  logic [ADDR_W-1:0]   it_addr;
  logic [PI_W-1:0]     it_pi;
  logic [SLOT_W-1:0]   it_target;
  logic [STATUS_W-1:0] res_status;
  logic [IW-1:0]       res_slot;
  logic [CW-1:0]       ptr;
  logic [IW-1:0]       chk_addr;

  // RAM ports
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic               vld_wr;
  logic [ENTRY_W-1:0] ent_wr;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               vld_rd;

  logic          tgt_oob;
  logic [IW-1:0] tgt_idx;
  logic          need_page;
  logic          pages_full;
  logic          alloc_stop;
  logic [CW-1:0] fc_grown;
  logic          nf_oob;
  logic [IW-1:0] nf_idx;
  logic          alloc_ok;
  logic          alloc_fresh;
  logic          up_found;
  logic          up_bound;
  logic          dn_found;
  logic          dn_zero;
  logic [CW-1:0] ptr_dec;

  always_comb begin
    tgt_oob     = 32'(it_target) >= CAP;
    tgt_idx     = IW'(it_target);
    need_page   = (fc == '0);
    pages_full  = (pages >= PW'(MAX_PAGES));
    alloc_stop  = need_page && pages_full;
    fc_grown    = need_page ? fc + CW'(SLOTS_PER_PAGE) : fc;
    nf_oob      = (nf >= CW'(CAP));
    nf_idx      = IW'(nf);
    alloc_ok    = !alloc_stop && !nf_oob;
    alloc_fresh = (nf == hw);
    up_found    = chk_v && !vld_rd;
    up_bound    = (ptr >= hw) || (ptr >= CW'(CAP));
    dn_found    = chk_v && vld_rd;
    dn_zero     = (ptr == '0);
    ptr_dec     = ptr - CW'(1);

    wr_en   = cmd.clr || (cmd.alloc && alloc_ok) || cmd.rel;
    wr_addr = cmd.clr ? clr_ptr : (cmd.alloc ? nf_idx : tgt_idx);
    vld_wr  = cmd.alloc;
    ent_wr  = cmd.alloc ? {it_addr, it_pi} : '0;

    rd_en   = cmd.unreg_rd
           || (cmd.up_step && !up_found && !up_bound)
           || (cmd.dn_step && !dn_found && !dn_zero);
    rd_addr = cmd.unreg_rd ? tgt_idx : (cmd.up_step ? IW'(ptr) : IW'(ptr_dec));

    sts.clr_last   = (clr_ptr == IW'(CAP - 1));
    sts.t_oob      = tgt_oob;
    sts.t_empty    = !vld_rd;
    sts.t_last     = last_pres && (tgt_idx == last_idx);
    sts.alloc_scan = alloc_ok && !alloc_fresh;
    sts.up_done    = up_found || up_bound;
    sts.dn_done    = dn_found || dn_zero;
    sts.out_busy   = out_valid && !out_ready;
  end

  stalm_ram #(.WIDTH(1), .DEPTH(CAP)) u_valid_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (vld_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (vld_rd)
  );

  // entry contents are kept but never reported
  stalm_ram #(.WIDTH(ENTRY_W), .DEPTH(CAP)) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ent_wr),
    .rd_en   (1'b0),
    .rd_addr ('0),
    .rd_data ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      nf        <= '0;
      hw        <= '0;
      last_idx  <= '0;
      last_pres <= 1'b0;
      fc        <= CW'(SLOTS_PER_PAGE);
      pages     <= PW'(1);
      clr_ptr   <= '0;
      chk_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr) clr_ptr <= clr_ptr + IW'(1);

      if (cmd.alloc && !alloc_stop) begin
        if (need_page) pages <= pages + PW'(1);
        fc <= nf_oob ? fc_grown : fc_grown - CW'(1);
        if (!nf_oob) begin
          if (alloc_fresh) begin
            last_idx  <= nf_idx;
            last_pres <= 1'b1;
            nf        <= nf + CW'(1);
            hw        <= hw + CW'(1);
          end else begin
            chk_v <= 1'b0;
          end
        end
      end

      if (cmd.up_step) begin
        if (up_found)      nf <= CW'(chk_addr);
        else if (up_bound) nf <= ptr;
        else               chk_v <= 1'b1;
      end

      if (cmd.unreg_chk) chk_v <= 1'b0;

      if (cmd.dn_step) begin
        if (dn_found) begin
          last_idx <= chk_addr;
        end else if (dn_zero) begin
          last_pres <= 1'b0;
          last_idx  <= '0;
        end else begin
          chk_v <= 1'b1;
        end
      end

      if (cmd.rel) begin
        if (CW'(tgt_idx) < nf) nf <= CW'(tgt_idx);
        fc <= fc + CW'(1);
      end

      if (cmd.finish)     out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_addr    <= in_item.page_addr;
      it_pi      <= in_item.producer_index;
      it_target  <= in_item.target_slot;
      res_status <= ST_OK;
      res_slot   <= '0;
    end
    if (cmd.alloc) begin
      if (!alloc_ok) begin
        res_status <= ST_FULL;
      end else begin
        res_slot <= nf_idx;
        ptr      <= nf + CW'(1);
      end
    end
    if (cmd.up_step && !up_found && !up_bound) begin
      chk_addr <= IW'(ptr);
      ptr      <= ptr + CW'(1);
    end
    if (cmd.unreg_rd && tgt_oob) res_status <= ST_EMPTY;
    if (cmd.unreg_chk) begin
      if (!vld_rd) res_status <= ST_EMPTY;
      ptr <= CW'(tgt_idx);
    end
    if (cmd.dn_step && !dn_found && !dn_zero) begin
      chk_addr <= IW'(ptr_dec);
      ptr      <= ptr_dec;
    end
    if (cmd.finish) begin
      out_item.status        <= res_status;
      out_item.assigned_slot <= SLOT_W'(res_slot);
      out_item.has_last      <= last_pres;
      out_item.last_slot     <= last_pres ? SLOT_W'(last_idx) : '0;
      out_item.free_slots    <= COUNT_W'(fc);
    end
  end
endmodule

// ----- design/slot_table_allocator_last_mark_unit.sv -----
// Top level of the lowest-free-slot allocator with last-entry mark.
// Depends on stalm_pkg, stalm_stream_if, stalm_ctrl, stalm_dp (and stalm_ram).
//
// Use:
//   req carries one request per transaction: func 0 registers page_addr and
//   producer_index in the lowest free slot, func 1 releases target_slot.
//   rsp carries one result per request: status (ok, table full, empty
//   slot), assigned_slot, the current last-marked entry and the free count.
// Sequencing:
//   One request is worked on at a time. A register into the fresh slot at
//   the high-water mark, or a refused register, goes from the allocation
//   step straight to the result. A register into a reused slot adds the
//   upward free scan (bounded by the high-water mark). An unregister reads
//   and judges the valid bit of the target slot, then clears it (a refused
//   one ends after the read or the judgement), with the downward scan first
//   when the released slot carried the last mark. The scans are bound by the
//   single read port of the valid-bit RAM: one slot per cycle.
//   req.ready returns the cycle after a result is loaded.
// Reset:
//   rst is synchronous. After it a clearing pass writes every slot of both
//   RAMs (SLOTS_PER_PAGE * MAX_PAGES slots, 1024 by default); req.ready
//   stays low until the pass ends.
// Stall:
//   Results sit in an output register. A stalled rsp holds its transaction;
//   the next request is still accepted and worked on, and waits only at the
//   point where its result would overwrite the one not yet taken.
module slot_table_allocator_last_mark_unit #(
  parameter int SLOTS_PER_PAGE = stalm_pkg::SLOTS_PER_PAGE_DEF,
  parameter int MAX_PAGES      = stalm_pkg::MAX_PAGES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  stalm_stream_if.sink   req,
  stalm_stream_if.source rsp
);
  import stalm_pkg::*;

  cmd_t      cmd;
  sts_t      sts;
  logic      ctrl_ready;
  logic      dp_out_valid;
  out_item_t dp_out_item;

  // controller: sequences clear pass, allocation, scans and release
  stalm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.payload.func),
    .req_ready (ctrl_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: counters, valid-bit RAM, entry RAM, result register
  stalm_dp #(
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE),
    .MAX_PAGES      (MAX_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (req.payload),
    .out_valid (dp_out_valid),
    .out_ready (rsp.ready),
    .out_item  (dp_out_item)
  );

  assign req.ready   = ctrl_ready;
  assign rsp.valid   = dp_out_valid;
  assign rsp.payload = dp_out_item;

  // one request in flight: acceptance is never followed by another at once
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in progress");

  // a full table report means no free slot is left in the pages in use
  a_full_no_free: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.status == ST_FULL) |-> (rsp.payload.free_slots == '0))
    else $error("table full reported with free slots remaining");

  // without a last mark the reported last slot is zero
  a_no_last_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.payload.has_last) |-> (rsp.payload.last_slot == '0))
    else $error("last slot reported without a last mark");

  // result register is loaded only when free or being emptied
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> ($stable(rsp.payload) && rsp.valid))
    else $error("stalled result changed");
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the slot table allocator with last-entry mark.
// Needs stalm_pkg, stalm_stream_if and the design sources; drives req and
// checks rsp against an in-bench prediction of the slot table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stalm_pkg::*;

  // Table geometry, matching the defaults the unit is built with
  localparam int unsigned PAGE_SLOTS  = SLOTS_PER_PAGE_DEF;
  localparam int unsigned PAGE_LIMIT  = MAX_PAGES_DEF;
  localparam int unsigned CAPACITY    = PAGE_SLOTS * PAGE_LIMIT;
  // Clearing pass and the longest scan both fit well inside
  localparam int unsigned STALL_LIMIT = 6000;

  logic clk;
  logic rst;

  stalm_stream_if #(.payload_t(in_item_t))  req ();
  stalm_stream_if #(.payload_t(out_item_t)) rsp ();

  slot_table_allocator_last_mark_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------
  // Predicted slot table. Only what shows in a result is kept: occupancy,
  // the allocation pointer, the high-water mark, the last mark and counts.
  // ---------------------------------------------------------------------
  bit          slot_valid [CAPACITY];
  int unsigned alloc_ptr  = 0;           // lowest free slot
  int unsigned fresh_mark = 0;           // first slot never handed out
  int unsigned tail_slot  = 0;           // entry carrying the last mark
  bit          tail_live  = 1'b0;
  int unsigned free_left  = PAGE_SLOTS;  // free slots within open pages
  int unsigned pages_open = 1;

  out_item_t   awaited_rsp [$];          // predicted results, oldest first

  // Run tallies, for the summary only
  int unsigned n_register   = 0;
  int unsigned n_release    = 0;
  int unsigned n_full       = 0;
  int unsigned n_empty      = 0;
  int unsigned n_mark_moves = 0;
  int unsigned mismatches   = 0;

  // Idling knobs, set per phase by the test tasks
  int unsigned req_gap_pct   = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned rsp_hold_left = 0;   // long hold-off, counted by the receiver

  // Apply one request to the predicted table and return the result it gives.
  function automatic out_item_t predict_allocation(in_item_t rq);
    out_item_t   o;
    int unsigned s;
    int unsigned i;
    bit          found;
    o = '0;
    if (rq.func == FUNC_REG) begin
      o.status = ST_OK;
      // Out of free slots: open another page if the bound allows it
      if (free_left == 0) begin
        if (pages_open >= PAGE_LIMIT) begin
          o.status = ST_FULL;
        end else begin
          pages_open++;
          free_left += PAGE_SLOTS;
        end
      end
      if (o.status == ST_OK && alloc_ptr >= CAPACITY) o.status = ST_FULL;
      if (o.status == ST_OK) begin
        s = alloc_ptr;
        slot_valid[s] = 1'b1;
        o.assigned_slot = SLOT_W'(s);
        free_left--;
        if (s == fresh_mark) begin
          // Fresh slot: it takes the last mark, pointer and mark advance
          tail_slot  = s;
          tail_live  = 1'b1;
          alloc_ptr  = s + 1;
          fresh_mark = fresh_mark + 1;
        end else begin
          // Reused slot: mark untouched, scan up for the next hole
          do alloc_ptr++;
          while (alloc_ptr < fresh_mark && alloc_ptr < CAPACITY && slot_valid[alloc_ptr]);
        end
      end
    end else begin
      s = rq.target_slot;
      if (!slot_valid[s]) begin
        o.status = ST_EMPTY;
      end else begin
        o.status = ST_OK;
        if (tail_live && s == tail_slot) begin
          // Releasing the marked entry: mark moves to the highest one below
          found = 1'b0;
          i = s;
          while (i > 0 && !found) begin
            i--;
            found = slot_valid[i];
          end
          if (found) begin
            tail_slot = i;
            n_mark_moves++;
          end else begin
            tail_live = 1'b0;
            tail_slot = 0;
          end
        end
        slot_valid[s] = 1'b0;
        if (s < alloc_ptr) alloc_ptr = s;
        free_left++;
      end
    end
    o.has_last   = tail_live;
    o.last_slot  = tail_live ? SLOT_W'(tail_slot) : '0;
    o.free_slots = COUNT_W'(free_left);
    return o;
  endfunction

  function automatic logic [ADDR_W-1:0] random_page();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return ADDR_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic in_item_t make_register(logic [ADDR_W-1:0] addr,
                                             logic [PI_W-1:0] pi);
    in_item_t rq;
    rq                = '0;
    rq.func           = FUNC_REG;
    rq.page_addr      = addr;
    rq.producer_index = pi;
    rq.target_slot    = SLOT_W'($urandom);   // ignored on register
    return rq;
  endfunction

  function automatic in_item_t make_release(logic [SLOT_W-1:0] slot);
    in_item_t rq;
    rq                = '0;
    rq.func           = FUNC_UNREG;
    rq.page_addr      = ADDR_W'({$urandom, $urandom});   // ignored
    rq.producer_index = PI_W'($urandom);
    rq.target_slot    = slot;
    return rq;
  endfunction

  // Some occupied slot below the high-water mark, or any slot if none
  function automatic logic [SLOT_W-1:0] pick_occupied_slot();
    int unsigned start;
    int unsigned k;
    int unsigned idx;
    if (fresh_mark == 0) return SLOT_W'($urandom);
    start = $urandom_range(fresh_mark - 1);
    for (k = 0; k < fresh_mark; k++) begin
      idx = (start + k) % fresh_mark;
      if (slot_valid[idx]) return SLOT_W'(idx);
    end
    return SLOT_W'($urandom);
  endfunction

  // Registers for reg_pct percent; else mostly well-formed releases of live entries,
  // the marked entry favoured so the downward scan runs often; the rest random noise.
  function automatic in_item_t random_request(int unsigned reg_pct);
    int unsigned pick;
    if ($urandom_range(99) < reg_pct) return make_register(random_page(), PI_W'($urandom));
    pick = $urandom_range(99);
    if (pick < 25 && tail_live) return make_release(SLOT_W'(tail_slot));
    if (pick < 88) return make_release(pick_occupied_slot());
    return make_release(SLOT_W'($urandom));
  endfunction

  // Offer one request; returns once the unit has accepted it. valid is left
  // high so back-to-back requests need no second assignment in one step.
  task automatic issue_request(input in_item_t rq, output out_item_t want);
    while ($urandom_range(99) < req_gap_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.payload <= rq;
    do @(posedge clk); while (!req.ready);
    want = predict_allocation(rq);
    awaited_rsp.push_back(want);
    if (rq.func == FUNC_REG) n_register++;
    else n_release++;
    if (want.status == ST_FULL)  n_full++;
    if (want.status == ST_EMPTY) n_empty++;
  endtask

  // Withdraw valid and wait until every predicted result has come back
  task automatic drain_block();
    req.valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------

  // Small table walk-through: empty-slot refusals, extreme field values,
  // holes, a reuse above the last mark and the mark falling away entirely.
  task automatic test_directed_cases();
    out_item_t want;
    req_gap_pct   = 0;
    rsp_stall_pct = 0;
    issue_request(make_release(SLOT_W'(0)), want);      // release on empty table
    issue_request(make_release('1), want);              // top slot, never used
    issue_request(make_register('1, '1), want);         // all-ones payload -> 0
    issue_request(make_register('0, '0), want);         // all-zeros payload -> 1
    issue_request(make_register(random_page(), PI_W'($urandom)), want);  // 2
    issue_request(make_register(random_page(), PI_W'($urandom)), want);  // 3, last
    issue_request(make_release(SLOT_W'(3)), want);      // mark steps down to 2
    issue_request(make_release(SLOT_W'(1)), want);      // hole, pointer to 1
    issue_request(make_register(random_page(), PI_W'($urandom)), want);  // 1, scan to 3
    issue_request(make_register(random_page(), PI_W'($urandom)), want);  // 3, above mark
    issue_request(make_release(SLOT_W'(2)), want);      // mark skips 3, lands on 1
    issue_request(make_release(SLOT_W'(0)), want);
    issue_request(make_release(SLOT_W'(1)), want);      // no entry below: mark gone
    issue_request(make_release(SLOT_W'(3)), want);
    issue_request(make_register('1, PI_W'(16'h8000)), want);  // reuse 0, still no mark
    issue_request(make_release(SLOT_W'(0)), want);
    issue_request(make_release(SLOT_W'(0)), want);      // same slot twice
    drain_block();
  endtask

  // Receiver holds off for a long stretch while requests keep coming: the
  // output register fills and req.ready must drop until rsp drains.
  task automatic test_output_backpressure();
    out_item_t want;
    req_gap_pct   = 0;
    rsp_stall_pct = 0;
    rsp_hold_left = 300;
    repeat (12) issue_request(make_register(random_page(), PI_W'($urandom)), want);
    drain_block();
  endtask

  task automatic test_random_traffic(int unsigned gap_pct, int unsigned stall_pct,
                                     int unsigned reg_pct, int unsigned count);
    out_item_t want;
    req_gap_pct   = gap_pct;
    rsp_stall_pct = stall_pct;
    repeat (count) issue_request(random_request(reg_pct), want);
    drain_block();
  endtask

  // Fill all pages until refused, punch holes low, middle and at the top,
  // refill them, then release everything in ascending order so the last
  // release of the marked entry scans the whole table down.
  task automatic test_table_exhaustion();
    out_item_t   want;
    int unsigned k;
    req_gap_pct   = 7;
    rsp_stall_pct = 7;
    do issue_request(make_register(random_page(), PI_W'($urandom)), want);
    while (want.status != ST_FULL);
    issue_request(make_register('1, '1), want);          // refused again
    issue_request(make_release('1), want);               // marked entry, top slot
    issue_request(make_release(SLOT_W'(512)), want);
    issue_request(make_release(SLOT_W'(0)), want);
    repeat (3) issue_request(make_register(random_page(), PI_W'($urandom)), want);
    issue_request(make_register(random_page(), PI_W'($urandom)), want);  // full
    for (k = 0; k < CAPACITY; k++) issue_request(make_release(SLOT_W'(k)), want);
    issue_request(make_release('1), want);               // already released
    repeat (20) issue_request(random_request(60), want);
    drain_block();
  endtask

  // ---------------------------------------------------------------------
  // Receiver and result checker: one transaction per edge at most
  // ---------------------------------------------------------------------
  function automatic void compare_field(string field, int unsigned want,
                                        int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  initial begin
    out_item_t got;
    out_item_t want;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        got = rsp.payload;
        if (awaited_rsp.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
        end else begin
          want = awaited_rsp.pop_front();
          compare_field("status",        want.status,        got.status);
          compare_field("assigned_slot", want.assigned_slot, got.assigned_slot);
          compare_field("has_last",      want.has_last,      got.has_last);
          compare_field("last_slot",     want.last_slot,     got.last_slot);
          compare_field("free_slots",    want.free_slots,    got.free_slots);
        end
      end
      if (rst) begin
        rsp.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
        rsp.ready <= 1'b0;
        rsp_hold_left--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a transaction for long
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles at %0t", STALL_LIMIT, $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------
  initial begin
    rst         <= 1'b1;
    req.valid   <= 1'b0;
    req.payload <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // first request waits out the clearing pass on req.ready
    test_directed_cases();
    test_output_backpressure();
    test_random_traffic(0,  0,  65, 125);   // no idling
    test_random_traffic(82, 0,  55, 125);   // sparse sender
    test_random_traffic(0,  82, 50, 125);   // stalling receiver
    test_random_traffic(7,  7,  55, 125);   // light idling on both sides
    test_table_exhaustion();
    repeat (40) @(posedge clk);             // nothing further may turn up
    $display("covered %0d requests: %0d registers, %0d releases, %0d full refusals,",
             n_register + n_release, n_register, n_release, n_full);
    $display("%0d empty-slot refusals, %0d moves of the last mark on release, %0d errors",
             n_empty, n_mark_moves, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/stalm_pkg.sv
design/stalm_stream_if.sv
design/stalm_ram.sv
design/stalm_ctrl.sv
design/stalm_dp.sv
design/slot_table_allocator_last_mark_unit.sv
tb/testbench.sv
